@@ rtl/stkmed_pkg.sv @@
`timescale 1ns / 1ps

package stkmed_pkg;

	// Storage geometry.
	localparam int STACK_DEPTH = 1024;
	localparam int VALUE_BITS  = 16;
	localparam int FIELD_BITS  = 16;
	localparam int ADDR_BITS   = $clog2(STACK_DEPTH);
	localparam int COUNT_BITS  = $clog2(STACK_DEPTH + 1);

	// Each half of the sorted copy lives in its own chain of cells.
	localparam int HALF_DEPTH  = (STACK_DEPTH + 1) / 2;
	localparam int HALF_BITS   = $clog2(HALF_DEPTH + 1);

	// Command codes.
	localparam logic [1:0] FUNC_PUSH = 2'd0;
	localparam logic [1:0] FUNC_POP  = 2'd1;
	localparam logic [1:0] FUNC_PEEK = 2'd2;

	// Response status codes.
	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_EMPTY = 1'b1;

	typedef logic [VALUE_BITS-1:0] value_t;

	// Operations applied by every cell of a chain at once. A chain holds
	// its values in descending order, cell 0 being the head.
	typedef enum logic [2:0] {
		CELL_HOLD,      // keep the contents
		CELL_INS,       // insert the key at its sorted place
		CELL_PUSHF,     // push the front value ahead of the head
		CELL_POPF,      // drop the head
		CELL_REM,       // remove one copy of the key
		CELL_REM_PUSHF, // remove one copy of the key, push the front value
		CELL_INS_POPF   // drop the head, insert the key at its sorted place
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		value_t   key;
		value_t   front;
	} chain_ctl_t;

	// Take a command field to the internal value width.
	function automatic value_t from_field(input logic [FIELD_BITS-1:0] x);
		logic [31:0] w;
		w = 32'(x);
		return w[VALUE_BITS-1:0];
	endfunction

	// Take an internal value to the response field width.
	function automatic logic [FIELD_BITS-1:0] to_field(input value_t x);
		logic [31:0] w;
		w = 32'(x);
		return w[FIELD_BITS-1:0];
	endfunction

endpackage

@@ rtl/stkmed_cmd_if.sv @@
`timescale 1ns / 1ps

interface stkmed_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [15:0] push_value;

	modport source (output valid, output func, output push_value, input ready);
	modport sink (input valid, input func, input push_value, output ready);
endinterface

@@ rtl/stkmed_rsp_if.sv @@
`timescale 1ns / 1ps

interface stkmed_rsp_if;
	logic        valid;
	logic        ready;
	logic        status;
	logic [15:0] result_value;

	modport source (output valid, output status, output result_value, input ready);
	modport sink (input valid, input status, input result_value, output ready);
endinterface

@@ rtl/stkmed_cell.sv @@
`timescale 1ns / 1ps

module stkmed_cell (
	input  logic                   clk,
	input  stkmed_pkg::chain_ctl_t ctl,
	input  logic                   occ,
	input  stkmed_pkg::value_t     prev_val,
	input  logic                   prev_ge,
	input  logic                   prev_le,
	input  stkmed_pkg::value_t     next_val,
	input  logic                   next_ge,
	output stkmed_pkg::value_t     val,
	output logic                   ge,
	output logic                   le
);
	import stkmed_pkg::*;

	value_t val_q;
	value_t val_nxt;

	// Compare flags of an occupied cell against the key of this cycle.
	assign ge  = occ && (val_q >= ctl.key);
	assign le  = occ && (val_q <= ctl.key);
	assign val = val_q;

	// Pick the new contents from this cell, its neighbors or the key.
	always_comb begin
		case (ctl.op)
			CELL_HOLD:      val_nxt = val_q;
			CELL_INS:       val_nxt = ge ? val_q : (prev_ge ? ctl.key : prev_val);
			CELL_PUSHF:     val_nxt = prev_val;
			CELL_POPF:      val_nxt = next_val;
			CELL_REM:       val_nxt = le ? next_val : val_q;
			CELL_REM_PUSHF: val_nxt = prev_le ? val_q : prev_val;
			CELL_INS_POPF:  val_nxt = next_ge ? next_val : (ge ? ctl.key : val_q);
			default:        val_nxt = val_q;
		endcase
	end

	always_ff @(posedge clk) begin
		val_q <= val_nxt;
	end

endmodule

@@ rtl/stkmed_chain.sv @@
`timescale 1ns / 1ps

module stkmed_chain (
	input  logic                            clk,
	input  stkmed_pkg::chain_ctl_t          ctl,
	input  logic [stkmed_pkg::HALF_BITS-1:0] size,
	output stkmed_pkg::value_t              head
);
	import stkmed_pkg::*;

	value_t val     [HALF_DEPTH];
	logic   ge      [HALF_DEPTH];
	logic   le      [HALF_DEPTH];
	value_t prev_val[HALF_DEPTH];
	logic   prev_ge [HALF_DEPTH];
	logic   prev_le [HALF_DEPTH];
	value_t next_val[HALF_DEPTH];
	logic   next_ge [HALF_DEPTH];

	assign head = val[0];

	for (genvar i = 0; i < HALF_DEPTH; i++) begin : g_cell
		// The head sees the front value as its upper neighbor.
		if (i == 0) begin : g_first
			assign prev_val[i] = ctl.front;
			assign prev_ge[i]  = 1'b1;
			assign prev_le[i]  = 1'b0;
		end else begin : g_inner_prev
			assign prev_val[i] = val[i-1];
			assign prev_ge[i]  = ge[i-1];
			assign prev_le[i]  = le[i-1];
		end

		// The last cell has nothing below it.
		if (i == HALF_DEPTH - 1) begin : g_last
			assign next_val[i] = '0;
			assign next_ge[i]  = 1'b0;
		end else begin : g_inner_next
			assign next_val[i] = val[i+1];
			assign next_ge[i]  = ge[i+1];
		end

		stkmed_cell u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.occ      (HALF_BITS'(i) < size),
			.prev_val (prev_val[i]),
			.prev_ge  (prev_ge[i]),
			.prev_le  (prev_le[i]),
			.next_val (next_val[i]),
			.next_ge  (next_ge[i]),
			.val      (val[i]),
			.ge       (ge[i]),
			.le       (le[i])
		);
	end

endmodule

@@ rtl/stack_with_median_query.sv @@
`timescale 1ns / 1ps

// LIFO stack of up to STACK_DEPTH values that also answers a lower-median
// query. A push or a peek of the median is done at acceptance, while a pop
// first reads the top value from the stack memory and then, in the next
// cycle, removes that value from the sorted copy. The sorted copy is kept
// in two chains of cells, the lower half in descending order and the upper
// half stored inverted, so that the head of the lower chain is always the
// median and every insertion or removal is one shift of the chains. A result
// sits in an output register; pushes are still taken while it waits, while
// pops and peeks wait until it has gone. A push to a full stack is dropped,
// and a pop or peek on an empty stack answers with the empty status and zero.
module stack_with_median_query (
	input logic          clk,
	input logic          arst_n,
	stkmed_cmd_if.sink   cmd,
	stkmed_rsp_if.source rsp
);
	import stkmed_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_POP  = 1'b1;

	logic                  state_q;
	logic [COUNT_BITS-1:0] cnt_q;
	logic                  rsp_valid_q;
	logic                  rsp_status_q;
	value_t                rsp_value_q;
	value_t                top_q;
	value_t                stack_mem [STACK_DEPTH];

	logic                  accept;
	logic                  is_push;
	logic                  is_query;
	logic                  pop_go;
	logic                  empty;
	logic                  full;
	logic                  cnt_even;
	value_t                in_value;
	value_t                key_value;
	value_t                lo_head;
	value_t                hi_head_inv;
	value_t                hi_head;
	logic [HALF_BITS-1:0]  lo_size;
	logic [HALF_BITS-1:0]  hi_size;
	logic [COUNT_BITS:0]   cnt_plus;
	chain_ctl_t            lo_ctl;
	chain_ctl_t            hi_ctl;

	assign is_push  = (cmd.func == FUNC_PUSH);
	assign is_query = (cmd.func == FUNC_POP) || (cmd.func == FUNC_PEEK);
	assign empty    = (cnt_q == '0);
	assign full     = (cnt_q == COUNT_BITS'(STACK_DEPTH));
	assign cnt_even = ~cnt_q[0];
	assign in_value = from_field(cmd.push_value);

	// Pops and peeks need a free output register; pushes do not.
	assign cmd.ready = (state_q == ST_IDLE) && (!is_query || !rsp_valid_q || rsp.ready);
	assign accept    = cmd.valid && cmd.ready;

	// A pop of a nonempty stack answers from the pop cycle, not at acceptance.
	assign pop_go = accept && (cmd.func == FUNC_POP) && !empty;

	// The lower half holds ceil(n/2) values, the upper half floor(n/2).
	assign cnt_plus = {1'b0, cnt_q} + (COUNT_BITS+1)'(1);
	assign lo_size  = HALF_BITS'(cnt_plus >> 1);
	assign hi_size  = HALF_BITS'(cnt_q >> 1);
	assign hi_head  = ~hi_head_inv;

	assign key_value = (state_q == ST_POP) ? top_q : in_value;

	// Chain control for the push and pop rebalancing.
	always_comb begin
		lo_ctl.op    = CELL_HOLD;
		lo_ctl.key   = key_value;
		lo_ctl.front = hi_head;
		hi_ctl.op    = CELL_HOLD;
		hi_ctl.key   = ~key_value;
		hi_ctl.front = ~lo_head;
		if (state_q == ST_POP) begin
			if (cnt_even) begin
				if (top_q <= lo_head) begin
					lo_ctl.op = CELL_REM_PUSHF;
					hi_ctl.op = CELL_POPF;
				end else begin
					hi_ctl.op = CELL_REM;
				end
			end else begin
				if (top_q <= lo_head) begin
					lo_ctl.op = CELL_REM;
				end else begin
					hi_ctl.op = CELL_REM_PUSHF;
					lo_ctl.op = CELL_POPF;
				end
			end
		end else if (accept && is_push && !full) begin
			if (cnt_even) begin
				if (hi_size == '0 || in_value <= hi_head) begin
					lo_ctl.op = CELL_INS;
				end else begin
					lo_ctl.op = CELL_PUSHF;
					hi_ctl.op = CELL_INS_POPF;
				end
			end else begin
				if (in_value >= lo_head) begin
					hi_ctl.op = CELL_INS;
				end else begin
					hi_ctl.op = CELL_PUSHF;
					lo_ctl.op = CELL_INS_POPF;
				end
			end
		end
	end

	stkmed_chain u_lo_chain (
		.clk  (clk),
		.ctl  (lo_ctl),
		.size (lo_size),
		.head (lo_head)
	);

	stkmed_chain u_hi_chain (
		.clk  (clk),
		.ctl  (hi_ctl),
		.size (hi_size),
		.head (hi_head_inv)
	);

	// Stack memory in push order; the top is read when a pop is taken.
	always_ff @(posedge clk) begin
		if (accept && is_push && !full) begin
			stack_mem[cnt_q[ADDR_BITS-1:0]] <= in_value;
		end
		if (accept && (cmd.func == FUNC_POP) && !empty) begin
			top_q <= stack_mem[ADDR_BITS'(cnt_q - COUNT_BITS'(1))];
		end
	end

	// Sequencer and entry count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && is_push && !full) begin
						cnt_q <= cnt_q + COUNT_BITS'(1);
					end
					if (accept && (cmd.func == FUNC_POP) && !empty) begin
						state_q <= ST_POP;
					end
				end
				ST_POP: begin
					cnt_q   <= cnt_q - COUNT_BITS'(1);
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Response register: one transaction per pop or peek.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == ST_POP) begin
			rsp_valid_q <= 1'b1;
		end else if (accept && is_query && !pop_go) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_POP) begin
			rsp_status_q <= STATUS_OK;
			rsp_value_q  <= top_q;
		end else if (accept && is_query && !pop_go) begin
			if (empty) begin
				rsp_status_q <= STATUS_EMPTY;
				rsp_value_q  <= '0;
			end else begin
				rsp_status_q <= STATUS_OK;
				rsp_value_q  <= lo_head;
			end
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.status       = rsp_status_q;
	assign rsp.result_value = to_field(rsp_value_q);

endmodule
